>>> sv/adcscan_pkg.sv
`timescale 1ns / 1ps

package adcscan_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCK_HALF  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRE_CMD   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONV      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHIP_GAP  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHAN_ORD  = 3'd4;

    localparam logic [7:0]  RST_SCK_HALF = 8'd6;
    localparam logic [7:0]  RST_PRE_CMD  = 8'd10;
    localparam logic [7:0]  RST_CONV     = 8'd60;
    localparam logic [7:0]  RST_CHIP_GAP = 8'd6;
    localparam logic [23:0] RST_CHAN_ORD = 24'd15673952;

    localparam logic [7:0] CMD_BASE = 8'h86;
    localparam logic [4:0] CMD_BITS = 5'd8;

    localparam int SAMPLE_W = 16;

    typedef struct packed {
        logic [7:0]  sck_half_ticks;
        logic [7:0]  pre_command_ticks;
        logic [7:0]  conversion_ticks;
        logic [7:0]  chip_gap_ticks;
        logic [23:0] channel_order;
    } cfg_t;

    typedef struct packed {
        logic                sck;
        logic                mosi;
        logic [2:0]          cs_n;
        logic                sample_valid;
        logic [SAMPLE_W-1:0] sample;
        logic [1:0]          chip_index;
        logic [2:0]          channel_index;
        logic                last;
        logic                busy_res;
    } result_t;

    function automatic logic [2:0] chan_code(input logic [23:0] order, input logic [2:0] pos);
        logic [2:0] code;
        code = 3'd0;
        unique case (pos)
            3'd0: code = order[2:0];
            3'd1: code = order[5:3];
            3'd2: code = order[8:6];
            3'd3: code = order[11:9];
            3'd4: code = order[14:12];
            3'd5: code = order[17:15];
            3'd6: code = order[20:18];
            3'd7: code = order[23:21];
            default: code = 3'd0;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] cmd_byte(input logic [2:0] code);
        return CMD_BASE | {1'b0, code, 4'b0000};
    endfunction

endpackage

>>> sv/adcscan_cfg.sv
`timescale 1ns / 1ps

module adcscan_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [adcscan_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [adcscan_pkg::CFG_DATA_W-1:0]  cfg_data,
    output adcscan_pkg::cfg_t                   cfg
);

    adcscan_pkg::cfg_t cfg_reg;
    adcscan_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                adcscan_pkg::CFG_SCK_HALF: cfg_next.sck_half_ticks    = cfg_data[7:0];
                adcscan_pkg::CFG_PRE_CMD:  cfg_next.pre_command_ticks = cfg_data[7:0];
                adcscan_pkg::CFG_CONV:     cfg_next.conversion_ticks  = cfg_data[7:0];
                adcscan_pkg::CFG_CHIP_GAP: cfg_next.chip_gap_ticks    = cfg_data[7:0];
                adcscan_pkg::CFG_CHAN_ORD: cfg_next.channel_order     = cfg_data[23:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sck_half_ticks    <= adcscan_pkg::RST_SCK_HALF;
            cfg_reg.pre_command_ticks <= adcscan_pkg::RST_PRE_CMD;
            cfg_reg.conversion_ticks  <= adcscan_pkg::RST_CONV;
            cfg_reg.chip_gap_ticks    <= adcscan_pkg::RST_CHIP_GAP;
            cfg_reg.channel_order     <= adcscan_pkg::RST_CHAN_ORD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/adc_scan_spi_sequencer.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// in        sink       in_valid / in_ready      start_req, miso (one beat per SPI tick)
// out       source     out_valid / out_ready    sck, mosi, cs_n, sample_valid, sample,
//                                               chip_index, channel_index, last, busy_res
// cfg       sink       cfg_write                cfg_index, cfg_data
//
// One beat in gives one beat out in the next cycle, from a single registered step.
// A new beat is taken every cycle while the output register is empty or being drained.
// in_ready falls only while the output beat is held by out_ready low.
// Reset returns the sequencer to idle and loads register defaults; the result register is not reset.

module adc_scan_spi_sequencer
#(
    parameter int NUM_CHIPS         = 3,
    parameter int CHANNELS_PER_CHIP = 8,
    parameter int SAMPLE_BITS       = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [adcscan_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [adcscan_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                start_req,
    input  logic                                miso,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                sck,
    output logic                                mosi,
    output logic [2:0]                          cs_n,
    output logic                                sample_valid,
    output logic [adcscan_pkg::SAMPLE_W-1:0]    sample,
    output logic [1:0]                          chip_index,
    output logic [2:0]                          channel_index,
    output logic                                last,
    output logic                                busy_res
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_PRE  = 3'd1;
    localparam logic [2:0] PH_CMD  = 3'd2;
    localparam logic [2:0] PH_CONV = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_GAP  = 3'd5;

    localparam logic [2:0] NC_W  = 3'(NUM_CHIPS);
    localparam logic [3:0] CPC_W = 4'(CHANNELS_PER_CHIP);
    localparam logic [4:0] SB_W  = 5'(SAMPLE_BITS);
    localparam int         SW    = adcscan_pkg::SAMPLE_W;

    adcscan_pkg::cfg_t cfg;

    adcscan_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic [2:0]    phase_reg,   phase_next;
    logic [7:0]    tick_reg,    tick_next;
    logic [4:0]    bit_reg,     bit_next;
    logic [1:0]    chip_reg,    chip_next;
    logic [2:0]    chan_reg,    chan_next;
    logic [7:0]    cmd_reg,     cmd_next;
    logic [SW-1:0] data_reg,    data_next;
    logic          clock_reg,   clock_next;
    logic          out_valid_reg, out_valid_next;

    adcscan_pkg::result_t res_reg, res_next;

    logic       in_fire;
    logic [7:0] half;
    logic [8:0] tc_inc;
    logic [4:0] bc_inc;
    logic [3:0] ch_inc;
    logic [2:0] chip_inc;
    logic       go_pre, go_cmd, go_conv, go_data, go_gap;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign half     = (cfg.sck_half_ticks == 8'd0) ? 8'd1 : cfg.sck_half_ticks;
    assign tc_inc   = {1'b0, tick_reg} + 9'd1;
    assign bc_inc   = bit_reg + 5'd1;
    assign ch_inc   = {1'b0, chan_reg} + 4'd1;
    assign chip_inc = {1'b0, chip_reg} + 3'd1;

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        chip_next  = chip_reg;
        chan_next  = chan_reg;
        cmd_next   = cmd_reg;
        data_next  = data_reg;
        clock_next = clock_reg;
        go_pre     = 1'b0;
        go_cmd     = 1'b0;
        go_conv    = 1'b0;
        go_data    = 1'b0;
        go_gap     = 1'b0;

        // pins reflect the state at the start of the tick
        res_next               = '0;
        res_next.busy_res      = (phase_reg != PH_IDLE);
        res_next.cs_n          = 3'b111;
        if (phase_reg == PH_PRE || phase_reg == PH_CMD || phase_reg == PH_CONV
            || phase_reg == PH_DATA)
        begin
            res_next.cs_n = 3'b111 & ~(3'b001 << chip_reg);
        end
        if (phase_reg == PH_CMD || phase_reg == PH_DATA)
        begin
            res_next.sck = clock_reg;
        end
        if (phase_reg == PH_CMD)
        begin
            res_next.mosi = cmd_reg[7];
        end

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    chip_next = 2'd0;
                    chan_next = 3'd0;
                    go_pre    = 1'b1;
                end
            end
            PH_PRE:
            begin
                tick_next = tc_inc[7:0];
                if (tc_inc >= {1'b0, cfg.pre_command_ticks})
                begin
                    go_cmd = 1'b1;
                end
            end
            PH_CMD:
            begin
                tick_next = tc_inc[7:0];
                if (tc_inc >= {1'b0, half})
                begin
                    tick_next = 8'd0;
                    if (clock_reg)
                    begin
                        clock_next = 1'b0;
                    end
                    else
                    begin
                        bit_next = bc_inc;
                        cmd_next = {cmd_reg[6:0], 1'b0};
                        if (bc_inc >= adcscan_pkg::CMD_BITS)
                        begin
                            go_conv = 1'b1;
                        end
                        else
                        begin
                            clock_next = 1'b1;
                        end
                    end
                end
            end
            PH_CONV:
            begin
                tick_next = tc_inc[7:0];
                if (tc_inc >= {1'b0, cfg.conversion_ticks})
                begin
                    go_data = 1'b1;
                end
            end
            PH_DATA:
            begin
                tick_next = tc_inc[7:0];
                if (tc_inc >= {1'b0, half})
                begin
                    tick_next = 8'd0;
                    if (clock_reg)
                    begin
                        clock_next = 1'b0;
                    end
                    else
                    begin
                        // sample after the falling edge
                        data_next = {data_reg[SW-2:0], miso};
                        bit_next  = bc_inc;
                        if (bc_inc >= SB_W)
                        begin
                            res_next.sample_valid  = 1'b1;
                            res_next.sample        = data_next;
                            res_next.chip_index    = chip_reg;
                            res_next.channel_index = chan_reg;
                            res_next.last          = (chip_inc >= NC_W) && (ch_inc >= CPC_W);
                            if (ch_inc < CPC_W)
                            begin
                                chan_next = ch_inc[2:0];
                                go_pre    = 1'b1;
                            end
                            else
                            begin
                                chan_next = 3'd0;
                                if (chip_inc < NC_W)
                                begin
                                    chip_next = chip_inc[1:0];
                                    go_gap    = 1'b1;
                                end
                                else
                                begin
                                    chip_next  = 2'd0;
                                    phase_next = PH_IDLE;
                                    tick_next  = 8'd0;
                                    bit_next   = 5'd0;
                                    clock_next = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            clock_next = 1'b1;
                        end
                    end
                end
            end
            PH_GAP:
            begin
                tick_next = tc_inc[7:0];
                if (tc_inc >= {1'b0, cfg.chip_gap_ticks})
                begin
                    go_pre = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                tick_next  = 8'd0;
                bit_next   = 5'd0;
                clock_next = 1'b0;
            end
        endcase

        // zero-length waits fall straight through to the following phase
        if (go_gap)
        begin
            clock_next = 1'b0;
            tick_next  = 8'd0;
            if (cfg.chip_gap_ticks == 8'd0)
            begin
                go_pre = 1'b1;
            end
            else
            begin
                phase_next = PH_GAP;
            end
        end
        if (go_pre)
        begin
            clock_next = 1'b0;
            tick_next  = 8'd0;
            if (cfg.pre_command_ticks == 8'd0)
            begin
                go_cmd = 1'b1;
            end
            else
            begin
                phase_next = PH_PRE;
            end
        end
        if (go_cmd)
        begin
            cmd_next   = adcscan_pkg::cmd_byte(adcscan_pkg::chan_code(cfg.channel_order,
                                                                      chan_next));
            phase_next = PH_CMD;
            tick_next  = 8'd0;
            bit_next   = 5'd0;
            clock_next = 1'b1;
        end
        if (go_conv)
        begin
            clock_next = 1'b0;
            tick_next  = 8'd0;
            if (cfg.conversion_ticks == 8'd0)
            begin
                go_data = 1'b1;
            end
            else
            begin
                phase_next = PH_CONV;
            end
        end
        if (go_data)
        begin
            phase_next = PH_DATA;
            tick_next  = 8'd0;
            bit_next   = 5'd0;
            data_next  = '0;
            clock_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= 8'd0;
            bit_reg       <= 5'd0;
            chip_reg      <= 2'd0;
            chan_reg      <= 3'd0;
            cmd_reg       <= 8'd0;
            data_reg      <= '0;
            clock_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                chip_reg  <= chip_next;
                chan_reg  <= chan_next;
                cmd_reg   <= cmd_next;
                data_reg  <= data_next;
                clock_reg <= clock_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sck           = res_reg.sck;
    assign mosi          = res_reg.mosi;
    assign cs_n          = res_reg.cs_n;
    assign sample_valid  = res_reg.sample_valid;
    assign sample        = res_reg.sample;
    assign chip_index    = res_reg.chip_index;
    assign channel_index = res_reg.channel_index;
    assign last          = res_reg.last;
    assign busy_res      = res_reg.busy_res;

endmodule

>>> dv/adc_scan_checker.sv
`timescale 1ns / 1ps

module adc_scan_checker
#(
    parameter int NUM_CHIPS         = 3,
    parameter int CHANNELS_PER_CHIP = 8,
    parameter int SAMPLE_BITS       = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [adcscan_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [adcscan_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                start_req,
    input  logic                                miso,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                sck,
    input  logic                                mosi,
    input  logic [2:0]                          cs_n,
    input  logic                                sample_valid,
    input  logic [adcscan_pkg::SAMPLE_W-1:0]    sample,
    input  logic [1:0]                          chip_index,
    input  logic [2:0]                          channel_index,
    input  logic                                last,
    input  logic                                busy_res,
    output int                                  errors,
    output int                                  pending
);

    localparam logic [2:0] SCAN_IDLE = 3'd0;
    localparam logic [2:0] SCAN_PRE  = 3'd1;
    localparam logic [2:0] SCAN_CMD  = 3'd2;
    localparam logic [2:0] SCAN_CONV = 3'd3;
    localparam logic [2:0] SCAN_DATA = 3'd4;
    localparam logic [2:0] SCAN_GAP  = 3'd5;

    adcscan_pkg::cfg_t regs;
    logic [2:0]        phase;
    logic [7:0]        ticks;
    logic [4:0]        bits;
    logic [1:0]        chip;
    logic [2:0]        chan;
    logic [7:0]        cmd_sr;
    logic [15:0]       data_sr;
    logic              clk_lvl;

    adcscan_pkg::result_t expected_beats[$];
    adcscan_pkg::result_t seen_beat;
    adcscan_pkg::result_t want_beat;
    int                   fail_count;

    function automatic void load_command();
        logic [2:0] code;
        code    = regs.channel_order[chan*3 +: 3];
        cmd_sr  = {1'b0, code, 4'b0000} | adcscan_pkg::CMD_BASE;
        phase   = SCAN_CMD;
        ticks   = '0;
        bits    = '0;
        clk_lvl = 1'b1;
    endfunction

    function automatic void begin_pre();
        clk_lvl = 1'b0;
        ticks   = '0;
        if (regs.pre_command_ticks == 8'd0)
            load_command();
        else
            phase = SCAN_PRE;
    endfunction

    function automatic void begin_data();
        phase   = SCAN_DATA;
        ticks   = '0;
        bits    = '0;
        data_sr = '0;
        clk_lvl = 1'b1;
    endfunction

    // one SPI tick: pins from the state at tick start, then advance
    function automatic adcscan_pkg::result_t scan_tick(input logic start, input logic din);
        adcscan_pkg::result_t r;
        logic [7:0]           half;
        logic [2:0]           next_chan;
        r        = '0;
        r.cs_n   = 3'b111;
        half     = (regs.sck_half_ticks == 8'd0) ? 8'd1 : regs.sck_half_ticks;
        r.busy_res = (phase != SCAN_IDLE);
        if (phase != SCAN_IDLE && phase != SCAN_GAP)
            r.cs_n[chip] = 1'b0;
        if (phase == SCAN_CMD || phase == SCAN_DATA)
            r.sck = clk_lvl;
        if (phase == SCAN_CMD)
            r.mosi = cmd_sr[7];

        case (phase)
            SCAN_IDLE:
            begin
                if (start)
                begin
                    chip = '0;
                    chan = '0;
                    begin_pre();
                end
            end
            SCAN_PRE:
            begin
                ticks++;
                if (ticks >= regs.pre_command_ticks)
                    load_command();
            end
            SCAN_CMD:
            begin
                ticks++;
                if (ticks >= half)
                begin
                    ticks = '0;
                    if (clk_lvl)
                        clk_lvl = 1'b0;
                    else
                    begin
                        bits++;
                        cmd_sr = cmd_sr << 1;
                        if (bits >= adcscan_pkg::CMD_BITS)
                        begin
                            clk_lvl = 1'b0;
                            ticks   = '0;
                            if (regs.conversion_ticks == 8'd0)
                                begin_data();
                            else
                                phase = SCAN_CONV;
                        end
                        else
                            clk_lvl = 1'b1;
                    end
                end
            end
            SCAN_CONV:
            begin
                ticks++;
                if (ticks >= regs.conversion_ticks)
                    begin_data();
            end
            SCAN_DATA:
            begin
                ticks++;
                if (ticks >= half)
                begin
                    ticks = '0;
                    if (clk_lvl)
                        clk_lvl = 1'b0;
                    else
                    begin
                        data_sr = {data_sr[14:0], din};
                        bits++;
                        if (bits >= SAMPLE_BITS)
                        begin
                            r.sample_valid  = 1'b1;
                            r.sample        = data_sr;
                            r.chip_index    = chip;
                            r.channel_index = chan;
                            r.last = (int'(chip) + 1 >= NUM_CHIPS) &&
                                     (int'(chan) + 1 >= CHANNELS_PER_CHIP);
                            next_chan = chan + 3'd1;
                            if (next_chan != 3'd0 && next_chan < CHANNELS_PER_CHIP)
                            begin
                                chan = next_chan;
                                begin_pre();
                            end
                            else
                            begin
                                chan = '0;
                                if (int'(chip) + 1 < NUM_CHIPS)
                                begin
                                    chip    = chip + 2'd1;
                                    clk_lvl = 1'b0;
                                    ticks   = '0;
                                    if (regs.chip_gap_ticks == 8'd0)
                                        begin_pre();
                                    else
                                        phase = SCAN_GAP;
                                end
                                else
                                begin
                                    chip    = '0;
                                    phase   = SCAN_IDLE;
                                    ticks   = '0;
                                    bits    = '0;
                                    clk_lvl = 1'b0;
                                end
                            end
                        end
                        else
                            clk_lvl = 1'b1;
                    end
                end
            end
            SCAN_GAP:
            begin
                ticks++;
                if (ticks >= regs.chip_gap_ticks)
                    begin_pre();
            end
            default:
            begin
                phase   = SCAN_IDLE;
                ticks   = '0;
                bits    = '0;
                clk_lvl = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.sck_half_ticks    = adcscan_pkg::RST_SCK_HALF;
            regs.pre_command_ticks = adcscan_pkg::RST_PRE_CMD;
            regs.conversion_ticks  = adcscan_pkg::RST_CONV;
            regs.chip_gap_ticks    = adcscan_pkg::RST_CHIP_GAP;
            regs.channel_order     = adcscan_pkg::RST_CHAN_ORD;
            phase      = SCAN_IDLE;
            ticks      = '0;
            bits       = '0;
            chip       = '0;
            chan       = '0;
            cmd_sr     = '0;
            data_sr    = '0;
            clk_lvl    = 1'b0;
            fail_count = 0;
            expected_beats.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    adcscan_pkg::CFG_SCK_HALF: regs.sck_half_ticks    = cfg_data[7:0];
                    adcscan_pkg::CFG_PRE_CMD:  regs.pre_command_ticks = cfg_data[7:0];
                    adcscan_pkg::CFG_CONV:     regs.conversion_ticks  = cfg_data[7:0];
                    adcscan_pkg::CFG_CHIP_GAP: regs.chip_gap_ticks    = cfg_data[7:0];
                    adcscan_pkg::CFG_CHAN_ORD: regs.channel_order     = cfg_data[23:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                expected_beats.push_back(scan_tick(start_req, miso));

            if (out_valid && out_ready)
            begin
                seen_beat = {sck, mosi, cs_n, sample_valid, sample, chip_index,
                             channel_index, last, busy_res};
                if (expected_beats.size() == 0)
                begin
                    $error("output beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want_beat = expected_beats.pop_front();
                    check_field("sck", 16'(want_beat.sck), 16'(seen_beat.sck));
                    check_field("mosi", 16'(want_beat.mosi), 16'(seen_beat.mosi));
                    check_field("cs_n", 16'(want_beat.cs_n), 16'(seen_beat.cs_n));
                    check_field("sample_valid", 16'(want_beat.sample_valid),
                                16'(seen_beat.sample_valid));
                    check_field("sample", want_beat.sample, seen_beat.sample);
                    check_field("chip_index", 16'(want_beat.chip_index),
                                16'(seen_beat.chip_index));
                    check_field("channel_index", 16'(want_beat.channel_index),
                                16'(seen_beat.channel_index));
                    check_field("last", 16'(want_beat.last), 16'(seen_beat.last));
                    check_field("busy_res", 16'(want_beat.busy_res),
                                16'(seen_beat.busy_res));
                end
            end

            errors  <= fail_count;
            pending <= expected_beats.size();
        end
    end

endmodule

>>> dv/tb_adc_scan_spi_sequencer.sv
`timescale 1ns / 1ps

module tb_adc_scan_spi_sequencer;

    localparam int NUM_CHIPS         = 3;
    localparam int CHANNELS_PER_CHIP = 8;
    localparam int SAMPLE_BITS       = 16;

    localparam int MAX_IDLE    = 11;
    localparam int STALL_LIMIT = 500;
    localparam int ITEM_TARGET = 800;

    localparam logic [adcscan_pkg::CFG_INDEX_W-1:0] SPARE_REG = 3'd7;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                cfg_write = 1'b0;
    logic [adcscan_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [adcscan_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    logic                                start_req = 1'b0;
    logic                                miso      = 1'b0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic                                sck;
    logic                                mosi;
    logic [2:0]                          cs_n;
    logic                                sample_valid;
    logic [adcscan_pkg::SAMPLE_W-1:0]    sample;
    logic [1:0]                          chip_index;
    logic [2:0]                          channel_index;
    logic                                last;
    logic                                busy_res;

    int errors;
    int pending;
    int ready_wait   = 0;
    int stall_cycles = 0;
    int items_sent   = 0;
    bit tx_no_gap    = 1'b0;
    bit rx_no_stall  = 1'b0;

    always #2 clk = ~clk;

    adc_scan_spi_sequencer
    #(
        .NUM_CHIPS         (NUM_CHIPS),
        .CHANNELS_PER_CHIP (CHANNELS_PER_CHIP),
        .SAMPLE_BITS       (SAMPLE_BITS)
    )
    dut
    (
        .*
    );

    adc_scan_checker
    #(
        .NUM_CHIPS         (NUM_CHIPS),
        .CHANNELS_PER_CHIP (CHANNELS_PER_CHIP),
        .SAMPLE_BITS       (SAMPLE_BITS)
    )
    checker_i
    (
        .*
    );

    // receiver: random wait before each output beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_wait <= 0;
        end
        else if (out_valid && out_ready)
        begin
            int w;
            w = rx_no_stall ? 0 : $urandom_range(0, MAX_IDLE);
            ready_wait <= w;
            out_ready  <= (w == 0);
        end
        else if (ready_wait != 0)
        begin
            ready_wait <= ready_wait - 1;
            out_ready  <= (ready_wait == 1);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles + 1 >= STALL_LIMIT)
        begin
            $display("adc_scan_spi_sequencer regression: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_beat(input logic start, input logic din);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        start_req <= start;
        miso      <= din;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // hold off until every expected output beat has gone
    task automatic settle_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] half, input logic [7:0] pre,
                                input logic [7:0] conv, input logic [7:0] gap,
                                input logic [23:0] order);
        logic [adcscan_pkg::CFG_INDEX_W-1:0] idx [6];
        logic [adcscan_pkg::CFG_DATA_W-1:0]  val [6];
        idx = '{adcscan_pkg::CFG_SCK_HALF, adcscan_pkg::CFG_PRE_CMD, adcscan_pkg::CFG_CONV,
                adcscan_pkg::CFG_CHIP_GAP, adcscan_pkg::CFG_CHAN_ORD, SPARE_REG};
        // upper bits of the 8-bit registers carry noise
        val[0] = {16'($urandom), half};
        val[1] = {16'($urandom), pre};
        val[2] = {16'($urandom), conv};
        val[3] = {16'($urandom), gap};
        val[4] = order;
        val[5] = 24'($urandom);
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(input int count);
        for (int i = 0; i < count; i++)
            send_beat($urandom_range(0, 3) == 0, 1'($urandom));
        settle_outputs();
    endtask

    initial
    begin
        logic [7:0] pick [4];
        int         sel;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timings: idle ticks, start, start while busy
        send_beat(1'b0, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b1, 1'b1);
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b1);
        send_beat(1'b1, 1'b1);
        settle_outputs();

        // zero half period, all waits skipped, highest channel codes
        program_regs(8'd0, 8'd0, 8'd0, 8'd0, 24'hFFFFFF);
        for (int i = 0; i < 18; i++)
            send_beat(i % 5 == 0, 1'(i));
        settle_outputs();

        // slowest timings mid-scan, lowest channel codes
        program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'h000000);
        run_phase(60);

        while (items_sent < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 9);
            for (int j = 0; j < 4; j++)
            begin
                if (sel < 7)
                    pick[j] = (j == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 3));
                else if (sel < 9)
                    pick[j] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else
                    pick[j] = 8'($urandom_range(1, 12));
            end
            tx_no_gap   = ($urandom_range(0, 4) == 0);
            rx_no_stall = ($urandom_range(0, 4) == 0);
            program_regs(pick[0], pick[1], pick[2], pick[3], 24'($urandom));
            run_phase($urandom_range(40, 250));
        end

        settle_outputs();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("adc_scan_spi_sequencer regression: pass");
        else
            $display("adc_scan_spi_sequencer regression: fail");
        $finish;
    end

endmodule
